// ===== src/first_fit_heap_allocator_assert.svh =====
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define FFHA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_WORDS_DEF = 4096;
    localparam int BYTES_W        = 14;
    localparam int WORD_W         = 12;
    localparam int SIZE_W         = 13;
    localparam int MEM_W          = SIZE_W + 1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_ZERO    = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   word;
    } t_result;

endpackage

// ===== src/ffha_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ffha_ctrl.sv =====
// Sequencer of the allocator: clearing pass, chain walk, free check, header update.
module ffha_ctrl #(
    parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS),
    localparam int CW = ((AW > ffha_pkg::SIZE_W) ? AW : ffha_pkg::SIZE_W) + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [ffha_pkg::BYTES_W-1:0] i_byte_count,
    input  logic [ffha_pkg::WORD_W-1:0]  i_payload_word,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output ffha_pkg::t_result            o_res,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [ffha_pkg::MEM_W-1:0]   o_mem_wdata,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [ffha_pkg::MEM_W-1:0]   i_mem_rdata
);

    localparam int SW = ffha_pkg::SIZE_W;

    ffha_pkg::t_state             r_state, n_state;
    logic [AW-1:0]                r_clr, n_clr;
    logic [CW-1:0]                r_h, n_h;
    logic [CW-1:0]                r_passed, n_passed;
    logic [SW-1:0]                r_words, n_words;
    logic [ffha_pkg::WORD_W-1:0]  r_pw, n_pw;
    ffha_pkg::t_result            r_res, n_res;

    logic [ffha_pkg::BYTES_W:0]   bytes_up;
    logic [SW-1:0]                words_in;
    logic [SW-1:0]                blk_size;
    logic                         blk_mark;
    logic                         walk_limit;
    logic                         end_overrun;
    logic [CW-1:0]                h_next;
    logic [CW-1:0]                in_pm1;
    logic [CW-1:0]                pw_hdr;

    // round the byte count up to whole words
    assign bytes_up = {1'b0, i_byte_count} + (ffha_pkg::BYTES_W + 1)'(3);
    assign words_in = SW'(bytes_up >> 2);

    // fields of the header just read
    assign blk_size = i_mem_rdata[SW-1:0];
    assign blk_mark = i_mem_rdata[SW];

    // walk checks on the block under the cursor
    assign walk_limit  = ((r_passed + CW'(r_words)) > CW'(HEAP_WORDS - 2))
                      || (r_h >= CW'(HEAP_WORDS));
    assign end_overrun = (r_h + CW'(r_words) + CW'(1)) > CW'(HEAP_WORDS);
    assign h_next      = r_h + CW'(blk_size) + CW'(1);

    // header index of a block to free
    assign in_pm1 = CW'(i_payload_word) - CW'(1);
    assign pw_hdr = CW'(r_pw) - CW'(1);

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_h      <= n_h;
        r_passed <= n_passed;
        r_words  <= n_words;
        r_pw     <= n_pw;
        r_res    <= n_res;
    end

    // next state, memory access and result
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_h         = r_h;
        n_passed    = r_passed;
        n_words     = r_words;
        n_pw        = r_pw;
        n_res       = r_res;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_h[AW-1:0];
        o_mem_wdata = '0;
        o_mem_raddr = r_h[AW-1:0];

        unique case (r_state)
            ffha_pkg::S_CLEAR: begin
                // zero one header per cycle
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(HEAP_WORDS - 1)) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            ffha_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action == ffha_pkg::ACT_FREE) begin
                        o_mem_raddr = in_pm1[AW-1:0];
                        n_pw        = i_payload_word;
                        n_state     = ffha_pkg::S_FREE;
                    end else if (words_in == '0) begin
                        n_res.status = ffha_pkg::ST_ZERO;
                        n_res.word   = '0;
                        n_state      = ffha_pkg::S_DONE;
                    end else begin
                        // start the walk at word 0
                        o_mem_raddr = '0;
                        n_h         = '0;
                        n_passed    = '0;
                        n_words     = words_in;
                        n_state     = ffha_pkg::S_WALK;
                    end
                end
            end
            ffha_pkg::S_WALK: begin
                priority if (walk_limit) begin
                    n_res.status = ffha_pkg::ST_NOMEM;
                    n_res.word   = '0;
                    n_state      = ffha_pkg::S_DONE;
                end else if ((blk_size == '0) || (!blk_mark && (blk_size >= r_words))) begin
                    if (end_overrun) begin
                        n_res.status = ffha_pkg::ST_NOMEM;
                        n_res.word   = '0;
                    end else begin
                        // take the block: end marker gets the request size
                        o_mem_we     = 1'b1;
                        o_mem_waddr  = r_h[AW-1:0];
                        o_mem_wdata  = {1'b1, (blk_size == '0) ? r_words : blk_size};
                        n_res.status = ffha_pkg::ST_OK;
                        n_res.word   = ffha_pkg::WORD_W'(r_h + CW'(1));
                    end
                    n_state = ffha_pkg::S_DONE;
                end else begin
                    // advance to the next header and read it at once
                    o_mem_raddr = h_next[AW-1:0];
                    n_h         = h_next;
                    n_passed    = r_passed + CW'(blk_size);
                end
            end
            ffha_pkg::S_FREE: begin
                n_res.word = '0;
                if ((r_pw == '0) || (pw_hdr >= CW'(HEAP_WORDS))
                    || (blk_size == '0) || !blk_mark) begin
                    n_res.status = ffha_pkg::ST_BADFREE;
                end else begin
                    // drop the allocated mark, keep the size
                    o_mem_we     = 1'b1;
                    o_mem_waddr  = pw_hdr[AW-1:0];
                    o_mem_wdata  = {1'b0, blk_size};
                    n_res.status = ffha_pkg::ST_OK;
                end
                n_state = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::S_CLEAR;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator: header memory, sequencer and output register.
// Allocate walks the header chain from word 0, one header read per cycle, to the first
// free block that fits or the end marker; free checks one header and, if valid, clears its mark.
// Requests are handled one at a time; the next is taken while the previous result waits.
// Synchronous active-low reset starts a clearing pass over every word of the header
// memory; no request is accepted until it ends.
module first_fit_heap_allocator #(
    parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [ffha_pkg::BYTES_W-1:0] i_byte_count,
    input  logic [ffha_pkg::WORD_W-1:0]  i_payload_word,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ffha_pkg::WORD_W-1:0]  o_result_word,
    output logic [1:0]                   o_status
);

    localparam int AW = $clog2(HEAP_WORDS);

    logic                        res_valid;
    logic                        res_ready;
    ffha_pkg::t_result           res;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [ffha_pkg::MEM_W-1:0]  mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [ffha_pkg::MEM_W-1:0]  mem_rdata;

    logic                        r_valid;
    ffha_pkg::t_result           r_out;

    // header memory: {allocated mark, payload size} per word
    ffha_ram #(
        .WIDTH (ffha_pkg::MEM_W),
        .DEPTH (HEAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffha_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_byte_count   (i_byte_count),
        .i_payload_word (i_payload_word),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_word = r_out.word;
    assign o_status      = r_out.status;

endmodule

// ===== src/ffha_checker.sv =====
// Port-level checker of the allocator and its bind to the top level.
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [ffha_pkg::WORD_W-1:0]  o_result_word,
    input logic [1:0]                   o_status
);

    // a stalled result transaction stays offered
    `FFHA_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")

    // failed requests report word zero
    `FFHA_ASSERT_NOW(a_fail_word, o_valid && (o_status != ffha_pkg::ST_OK), o_result_word == '0, "failed request with nonzero word")

    // one request in work at a time: ready drops after an input transaction
    `FFHA_ASSERT_NEXT_ALWAYS(a_one_at_a_time, i_valid && o_ready, !o_ready, "taken while busy")

    // reset empties the output register and drops ready
    `FFHA_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid && !o_ready, "busy after reset")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_word (o_result_word),
    .o_status      (o_status)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the first-fit heap allocator with a built-in heap predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int HEAP_WORDS     = HEAP_WORDS_DEF;
    localparam int STALL_PCT      = 25;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int FREED_KEEP     = 64;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                i_action       = 1'b0;
    logic [BYTES_W-1:0]  i_byte_count   = '0;
    logic [WORD_W-1:0]   i_payload_word = '0;
    logic                i_ready        = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [WORD_W-1:0]   o_result_word;
    logic [1:0]          o_status;

    // Predictor copy of the heap headers
    logic [SIZE_W-1:0]   hdr_size [HEAP_WORDS];
    bit                  hdr_used [HEAP_WORDS];

    t_result             pending_results [$];
    t_result             oldest_result;
    logic [WORD_W-1:0]   live_words [$];
    logic [WORD_W-1:0]   freed_words [$];
    bit                  no_idle = 1'b0;
    int                  error_count = 0;
    int                  quiet_cycles = 0;

    first_fit_heap_allocator #(
        .HEAP_WORDS(HEAP_WORDS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_action(i_action),
        .i_byte_count(i_byte_count),
        .i_payload_word(i_payload_word),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_result_word(o_result_word),
        .o_status(o_status)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random unless a calm stretch is running
    always @(negedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= STALL_PCT);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Clear every header, as after reset
    task automatic clear_heap_model;
        for (int i = 0; i < HEAP_WORDS; i++) begin
            hdr_size[i] = '0;
            hdr_used[i] = 1'b0;
        end
    endtask

    // Apply one allocate or free to the heap copy and return its result
    function automatic t_result predict_heap_op(input t_action act,
                                                input logic [BYTES_W-1:0] bytes,
                                                input logic [WORD_W-1:0] pw);
        t_result r;
        int      words;
        int      h;
        int      passed;
        int      w;
        bit      found;
        r.word   = '0;
        r.status = ST_OK;
        if (act == ACT_FREE) begin
            h = int'(pw) - 1;
            if (pw == '0 || h >= HEAP_WORDS || hdr_size[h] == '0 || !hdr_used[h]) begin
                r.status = ST_BADFREE;
            end else begin
                hdr_used[h] = 1'b0;
            end
            return r;
        end
        words = (int'(bytes) + 3) / 4;
        if (words == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        // Walk the chain to the first free block that fits, or the end marker
        h      = 0;
        passed = 0;
        found  = 1'b0;
        while (!found) begin
            if (passed + words > HEAP_WORDS - 2 || h >= HEAP_WORDS) begin
                r.status = ST_NOMEM;
                return r;
            end
            w = int'(hdr_size[h]);
            if (w == 0 || (!hdr_used[h] && w >= words)) begin
                found = 1'b1;
            end else begin
                passed += w;
                h      += w + 1;
            end
        end
        if (words > HEAP_WORDS - (h + 1)) begin
            r.status = ST_NOMEM;
            return r;
        end
        if (hdr_size[h] == '0) hdr_size[h] = SIZE_W'(words);
        hdr_used[h] = 1'b1;
        r.word = WORD_W'(h + 1);
        return r;
    endfunction

    // Send one request transaction; entered and left at a falling edge
    task automatic send_request(input t_action act, input logic [BYTES_W-1:0] bytes,
                                input logic [WORD_W-1:0] pw);
        t_result want;
        while (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_byte_count   <= bytes;
        i_payload_word <= pw;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = predict_heap_op(act, bytes, pw);
        pending_results.push_back(want);
        if (act == ACT_ALLOC && want.status == ST_OK) live_words.push_back(want.word);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every pending result has arrived
    task automatic wait_for_results;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Zero size, oversize and the smallest sizes with their word rounding
    task automatic test_size_edges;
        send_request(ACT_ALLOC, 14'd0, 12'hFFF);
        send_request(ACT_ALLOC, 14'h3FFF, 12'd0);
        send_request(ACT_ALLOC, 14'd16380, 12'd0);
        send_request(ACT_ALLOC, 14'd16377, 12'd0);
        send_request(ACT_ALLOC, 14'd1, 12'hFFF);
        send_request(ACT_ALLOC, 14'd3, 12'd0);
        send_request(ACT_ALLOC, 14'd4, 12'd0);
        send_request(ACT_ALLOC, 14'd5, 12'd0);
        send_request(ACT_ALLOC, 14'd16, 12'd0);
        wait_for_results;
    endtask

    // Valid, double, null, out-of-chain and mid-payload frees, then block reuse
    task automatic test_free_and_reuse;
        send_request(ACT_FREE, 14'h3FFF, 12'd1);
        send_request(ACT_FREE, 14'd0, 12'd1);
        send_request(ACT_FREE, 14'd0, 12'd0);
        send_request(ACT_FREE, 14'd0, 12'hFFF);
        send_request(ACT_FREE, 14'd0, 12'd8);
        send_request(ACT_FREE, 14'd0, 12'd3);
        send_request(ACT_ALLOC, 14'd2, 12'd0);
        send_request(ACT_ALLOC, 14'd8, 12'd0);
        send_request(ACT_ALLOC, 14'd4, 12'd0);
        send_request(ACT_FREE, 14'd0, 12'd7);
        send_request(ACT_ALLOC, 14'd5, 12'd0);
        wait_for_results;
    endtask

    // Mixed traffic: mostly small allocations and frees of live blocks
    task automatic test_random_traffic(input int n_items, input bit calm);
        t_action            act;
        logic [BYTES_W-1:0] bytes;
        logic [WORD_W-1:0]  pw;
        int                 kind;
        int                 pick;
        no_idle = calm;
        repeat (n_items) begin
            act   = ACT_ALLOC;
            bytes = BYTES_W'($urandom);
            pw    = WORD_W'($urandom);
            kind  = $urandom_range(0, 99);
            if (kind < 55) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) bytes = BYTES_W'($urandom_range(1, 64));
                else if (pick < 90) bytes = BYTES_W'($urandom_range(65, 512));
                else if (pick < 96) bytes = BYTES_W'($urandom_range(513, 16383));
            end else if (kind < 58) begin
                bytes = '0;
            end else if (kind < 88) begin
                act = ACT_FREE;
                if (live_words.size() > 0) begin
                    pick = $urandom_range(0, live_words.size() - 1);
                    pw   = live_words[pick];
                    live_words.delete(pick);
                    freed_words.push_back(pw);
                    if (freed_words.size() > FREED_KEEP) void'(freed_words.pop_front());
                end
            end else if (kind < 94) begin
                act = ACT_FREE;
                if (freed_words.size() > 0) begin
                    pw = freed_words[$urandom_range(0, freed_words.size() - 1)];
                end
            end else begin
                act = ACT_FREE;
            end
            send_request(act, bytes, pw);
        end
        wait_for_results;
        no_idle = 1'b0;
    endtask

    // Aim at the heap end: one word too many, an exact fit, then a walk off the end
    task automatic test_heap_end;
        int h;
        int rem;
        int bytes_i;
        h = 0;
        while (h < HEAP_WORDS && hdr_size[h] != '0) h += int'(hdr_size[h]) + 1;
        rem = HEAP_WORDS - (h + 1);
        if (rem >= 0) begin
            bytes_i = (rem + 1) * 4;
            if (bytes_i > 16383) bytes_i = 16383;
            send_request(ACT_ALLOC, BYTES_W'(bytes_i), 12'd0);
            if (rem > 0) send_request(ACT_ALLOC, BYTES_W'(rem * 4), 12'd0);
        end
        send_request(ACT_ALLOC, 14'd4, 12'd0);
        send_request(ACT_ALLOC, 14'd1, 12'd0);
        send_request(ACT_FREE, 14'd0, WORD_W'(HEAP_WORDS - 1));
        wait_for_results;
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", int'(o_status), -1);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    report_mismatch("status", int'(o_status), int'(oldest_result.status));
                end
                if (o_result_word !== oldest_result.word) begin
                    report_mismatch("result_word", int'(o_result_word),
                                    int'(oldest_result.word));
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_heap_model();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_size_edges();
        test_free_and_reuse();
        test_random_traffic(320, 1'b1);
        test_random_traffic(600, 1'b0);
        test_heap_end();

        // Let any stray result show up before the verdict
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never arrived", 0, pending_results.size());
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
